/* design/cifr_pkg.sv */
// Shared types and constants of the character image flip/rotate engine.
`default_nettype none

package cifr_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WR_PRIMARY   = 2'd0,
        REQ_WR_SECONDARY = 2'd1,
        REQ_READ         = 2'd2,
        REQ_NONE         = 2'd3
    } req_t;

    // Transform modes; codes 6 and 7 pass the primary pixel through
    typedef enum logic [2:0] {
        MODE_MIRROR_COL  = 3'd0,
        MODE_MIRROR_ROW  = 3'd1,
        MODE_ROT_LEFT    = 3'd2,
        MODE_ROT_RIGHT   = 3'd3,
        MODE_INVERT      = 3'd4,
        MODE_SUPERIMPOSE = 3'd5,
        MODE_PASS_A      = 3'd6,
        MODE_PASS_B      = 3'd7
    } mode_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MODE      = 1'b0,
        CFG_SIDE_LAST = 1'b1
    } cfg_idx_t;

    localparam logic [2:0] MODE_RESET      = 3'd0;
    localparam logic [5:0] SIDE_LAST_RESET = 6'd57;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // Read request after coordinate remap
    typedef struct packed {
        logic       outside;  // requested position lies beyond the image
        logic [5:0] prim_row; // primary image position to fetch
        logic [5:0] prim_col;
        mode_t      mode;
    } rd_ctl_t;

endpackage

`default_nettype wire

/* design/cifr_img_ram.sv */
// Single image store: one write port, one registered read port.
`default_nettype none

module cifr_img_ram #(
    parameter int SIDE = 64,
    parameter int CW   = 6
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [CW-1:0] wr_row,
    input  wire logic [CW-1:0] wr_col,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [CW-1:0] rd_row,
    input  wire logic [CW-1:0] rd_col,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [SIDE][SIDE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_col] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_row][rd_col];
        end
    end

endmodule

`default_nettype wire

/* design/cifr_remap.sv */
// Maps a requested output position to the primary image position it shows.
`default_nettype none

module cifr_remap #(
    parameter int SIDE = 64
) (
    input  wire logic [2:0]     mode,
    input  wire logic [5:0]     side_last,
    input  wire logic [5:0]     row,
    input  wire logic [5:0]     col,
    output cifr_pkg::rd_ctl_t   ctl
);
    import cifr_pkg::*;

    localparam logic [5:0] LAST_MAX = 6'(SIDE - 1);

    logic [5:0] last;
    logic [5:0] last_m_row;
    logic [5:0] last_m_col;
    mode_t      mode_e;

    always_comb begin
        // clamp the image to the store
        last       = (side_last > LAST_MAX) ? LAST_MAX : side_last;
        last_m_row = last - row;
        last_m_col = last - col;
        mode_e     = mode_t'(mode);

        ctl.outside = (row > last) || (col > last);
        ctl.mode    = mode_e;
        unique case (mode_e)
            MODE_MIRROR_COL: begin
                ctl.prim_row = row;
                ctl.prim_col = last_m_col;
            end
            MODE_MIRROR_ROW: begin
                ctl.prim_row = last_m_row;
                ctl.prim_col = col;
            end
            MODE_ROT_LEFT: begin
                ctl.prim_row = col;
                ctl.prim_col = last_m_row;
            end
            MODE_ROT_RIGHT: begin
                ctl.prim_row = last_m_col;
                ctl.prim_col = row;
            end
            default: begin
                ctl.prim_row = row;
                ctl.prim_col = col;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/char_image_flip_rotate_engine_top.sv */
// Top level of the character image flip/rotate engine.
`default_nettype none

// Holds a primary and a secondary square character image of SIDE x SIDE
// entries. Write requests store one pixel; read requests return the pixel
// that the configured mode (mirror, rotate, invert, superimpose) puts at the
// requested position of the image whose last index is side_last. One
// request is taken every cycle while the result channel keeps up; a waiting
// result holds the whole pipeline and the input with it. A read result is
// presented from the output register: the image read and the request's
// mode and range flag are registered when the request is taken, then the
// character map loads the output register. A pixel written in one cycle is
// seen by a read in the next. Images hold no defined contents until written.
module char_image_flip_rotate_engine_top #(
    parameter int SIDE = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_index,
    input  wire logic [5:0] cfg_data,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [5:0] s_row,
    input  wire logic [5:0] s_col,
    input  wire logic [7:0] s_pixel_in,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_pixel_out
);
    import cifr_pkg::*;

    localparam int         CW     = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam logic [6:0] SIDE_W = 7'(SIDE);

    logic [2:0] mode_reg;
    logic [5:0] side_last_reg;

    logic       advance;
    logic       s_fire;
    logic       wr_in_range;
    logic       wr_prim;
    logic       wr_sec;
    req_t       req;
    rd_ctl_t    ctl;

    logic       s1_valid_reg;
    logic       s1_outside_reg;
    mode_t      s1_mode_reg;
    logic [7:0] prim_rd;
    logic [7:0] sec_rd;

    logic       m_valid_reg;
    logic [7:0] m_pixel_out_reg;
    logic [7:0] pixel_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RESET;
            side_last_reg <= SIDE_LAST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:      mode_reg      <= cfg_data[2:0];
                CFG_SIDE_LAST: side_last_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // advance the whole pipeline whenever the output register is free
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign s_fire  = s_valid && s_ready;
    assign req     = req_t'(s_req_type);

    // drop writes outside the store
    assign wr_in_range = ({1'b0, s_row} < SIDE_W) && ({1'b0, s_col} < SIDE_W);
    assign wr_prim     = s_fire && wr_in_range && (req == REQ_WR_PRIMARY);
    assign wr_sec      = s_fire && wr_in_range && (req == REQ_WR_SECONDARY);

    cifr_remap #(
        .SIDE (SIDE)
    ) u_remap (
        .mode      (mode_reg),
        .side_last (side_last_reg),
        .row       (s_row),
        .col       (s_col),
        .ctl       (ctl)
    );

    cifr_img_ram #(
        .SIDE (SIDE),
        .CW   (CW)
    ) u_prim_ram (
        .aclk    (aclk),
        .wr_en   (wr_prim),
        .wr_row  (s_row[CW-1:0]),
        .wr_col  (s_col[CW-1:0]),
        .wr_data (s_pixel_in),
        .rd_en   (advance),
        .rd_row  (ctl.prim_row[CW-1:0]),
        .rd_col  (ctl.prim_col[CW-1:0]),
        .rd_data (prim_rd)
    );

    cifr_img_ram #(
        .SIDE (SIDE),
        .CW   (CW)
    ) u_sec_ram (
        .aclk    (aclk),
        .wr_en   (wr_sec),
        .wr_row  (s_row[CW-1:0]),
        .wr_col  (s_col[CW-1:0]),
        .wr_data (s_pixel_in),
        .rd_en   (advance),
        .rd_row  (s_row[CW-1:0]),
        .rd_col  (s_col[CW-1:0]),
        .rd_data (sec_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_fire && (req == REQ_READ);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_outside_reg <= ctl.outside;
            s1_mode_reg    <= ctl.mode;
        end
    end

    always_comb begin
        pixel_next = prim_rd;
        if (s1_outside_reg) begin
            pixel_next = 8'd0;
        end else begin
            unique case (s1_mode_reg)
                MODE_INVERT: begin
                    if (prim_rd == CH_UNDERSCORE || prim_rd == CH_DOT) begin
                        pixel_next = CH_AT;
                    end else if (prim_rd == CH_EQUALS) begin
                        pixel_next = CH_HASH;
                    end else if (prim_rd == CH_AT) begin
                        pixel_next = CH_UNDERSCORE;
                    end else if (prim_rd == CH_HASH) begin
                        pixel_next = CH_EQUALS;
                    end else begin
                        pixel_next = CH_DOT;
                    end
                end
                MODE_SUPERIMPOSE: pixel_next = (sec_rd == CH_SPACE) ? prim_rd : sec_rd;
                default:          pixel_next = prim_rd;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pixel_out_reg <= pixel_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_out_reg;

endmodule

`default_nettype wire
